FILE: sv/rae_pkg.sv
// Shared types, opcodes and constants of the register ALU instruction executor.
package rae_pkg;

    localparam int RAE_NUM_REGISTERS = 16;
    localparam int RAE_QUEUE_DEPTH = 2;
    localparam int RAE_QUEUE_AW = (RAE_QUEUE_DEPTH > 1) ? $clog2(RAE_QUEUE_DEPTH) : 1;
    localparam int RAE_DIV_STEPS = 32;
    localparam int RAE_DIV_CW = $clog2(RAE_DIV_STEPS);

    localparam logic [7:0] OPC_LDI    = 8'h00;
    localparam logic [7:0] OPC_ADD_RR = 8'h10;
    localparam logic [7:0] OPC_ADD_RI = 8'h11;
    localparam logic [7:0] OPC_SUB_RR = 8'h20;
    localparam logic [7:0] OPC_SUB_RI = 8'h21;
    localparam logic [7:0] OPC_MUL_RR = 8'h30;
    localparam logic [7:0] OPC_MUL_RI = 8'h31;
    localparam logic [7:0] OPC_DIV_RR = 8'h40;

    localparam logic [2:0] LAT_ALU = 3'd1;
    localparam logic [2:0] LAT_MUL = 3'd2;
    localparam logic [2:0] LAT_DIV = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_IDX  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    typedef enum logic [2:0] {
        OPK_LDI,
        OPK_ADD,
        OPK_SUB,
        OPK_MUL,
        OPK_DIV
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic       right_is_reg;
        logic       idx_err;
        logic [2:0] latency;
        logic [7:0] rd;
        logic [7:0] lb;
        logic [7:0] rb;
    } rae_uop_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EXEC,
        BK_DIV,
        BK_FIX,
        BK_DONE
    } back_state_t;

endpackage

FILE: sv/rae_in_if.sv
// Instruction channel: four instruction bytes with valid/ready.
interface rae_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] opcode_byte;
    logic [7:0] dest_index;
    logic [7:0] left_byte;
    logic [7:0] right_byte;

    modport source (output valid, output opcode_byte, output dest_index,
                    output left_byte, output right_byte, input ready);
    modport sink (input valid, input opcode_byte, input dest_index,
                  input left_byte, input right_byte, output ready);
endinterface

FILE: sv/rae_out_if.sv
// Result channel: write-back report and counters with valid/ready.
interface rae_out_if;
    logic               valid;
    logic               ready;
    logic [7:0]         written_index;
    logic signed [31:0] written_value;
    logic               did_write;
    logic [2:0]         latency_cycles;
    logic [31:0]        cycle_total;
    logic [31:0]        instruction_total;
    logic [1:0]         status_code;

    modport source (output valid, output written_index, output written_value,
                    output did_write, output latency_cycles, output cycle_total,
                    output instruction_total, output status_code, input ready);
    modport sink (input valid, input written_index, input written_value,
                  input did_write, input latency_cycles, input cycle_total,
                  input instruction_total, input status_code, output ready);
endinterface

FILE: sv/rae_front.sv
// Front end: accepts instruction items, decodes opcode and checks register indexes.
module rae_front
    import rae_pkg::*;
#(
    parameter int NUM_REGISTERS = RAE_NUM_REGISTERS
)
(
    rae_in_if.sink     instr,
    output logic       uop_valid,
    input  logic       uop_ready,
    output rae_uop_t   uop
);

    localparam logic [8:0] NREG = 9'(NUM_REGISTERS);

    op_kind_t   kind;
    logic       right_is_reg;
    logic [2:0] latency;
    logic       rd_ok;
    logic       lb_ok;
    logic       rb_ok;

    always_comb
    begin
        unique case (instr.opcode_byte)
            OPC_LDI:
            begin
                kind = OPK_LDI; right_is_reg = 1'b0; latency = LAT_ALU;
            end
            OPC_ADD_RR:
            begin
                kind = OPK_ADD; right_is_reg = 1'b1; latency = LAT_ALU;
            end
            OPC_ADD_RI:
            begin
                kind = OPK_ADD; right_is_reg = 1'b0; latency = LAT_ALU;
            end
            OPC_SUB_RR:
            begin
                kind = OPK_SUB; right_is_reg = 1'b1; latency = LAT_ALU;
            end
            OPC_SUB_RI:
            begin
                kind = OPK_SUB; right_is_reg = 1'b0; latency = LAT_ALU;
            end
            OPC_MUL_RR:
            begin
                kind = OPK_MUL; right_is_reg = 1'b1; latency = LAT_MUL;
            end
            OPC_MUL_RI:
            begin
                kind = OPK_MUL; right_is_reg = 1'b0; latency = LAT_MUL;
            end
            OPC_DIV_RR:
            begin
                kind = OPK_DIV; right_is_reg = 1'b1; latency = LAT_DIV;
            end
            default:
            begin
                // unknown opcodes execute as divide by immediate
                kind = OPK_DIV; right_is_reg = 1'b0; latency = LAT_DIV;
            end
        endcase
    end

    assign rd_ok = {1'b0, instr.dest_index} < NREG;
    assign lb_ok = {1'b0, instr.left_byte} < NREG;
    assign rb_ok = {1'b0, instr.right_byte} < NREG;

    always_comb
    begin
        uop.kind         = kind;
        uop.right_is_reg = right_is_reg;
        uop.latency      = latency;
        uop.rd           = instr.dest_index;
        uop.lb           = instr.left_byte;
        uop.rb           = instr.right_byte;
        uop.idx_err      = !rd_ok ||
                           ((kind != OPK_LDI) && (!lb_ok || (right_is_reg && !rb_ok)));
    end

    assign uop_valid   = instr.valid;
    assign instr.ready = uop_ready;

endmodule

FILE: sv/rae_queue.sv
// Short FIFO of decoded items between front and back end.
module rae_queue
    import rae_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  rae_uop_t push_data,
    output logic     pop_valid,
    input  logic     pop_ready,
    output rae_uop_t pop_data
);

    localparam logic [RAE_QUEUE_AW:0] DEPTH = (RAE_QUEUE_AW + 1)'(RAE_QUEUE_DEPTH);
    localparam logic [RAE_QUEUE_AW-1:0] LAST = RAE_QUEUE_AW'(RAE_QUEUE_DEPTH - 1);

    rae_uop_t                slot_reg [RAE_QUEUE_DEPTH];
    logic [RAE_QUEUE_AW-1:0] wr_ptr_reg;
    logic [RAE_QUEUE_AW-1:0] wr_ptr_next;
    logic [RAE_QUEUE_AW-1:0] rd_ptr_reg;
    logic [RAE_QUEUE_AW-1:0] rd_ptr_next;
    logic [RAE_QUEUE_AW:0]   count_reg;
    logic [RAE_QUEUE_AW:0]   count_next;
    logic                    do_push;
    logic                    do_pop;

    assign push_ready = count_reg != DEPTH;
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: sv/rae_back.sv
// Back end: register file, ALU, iterative divider, counters and result register.
module rae_back
    import rae_pkg::*;
#(
    parameter int NUM_REGISTERS = RAE_NUM_REGISTERS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        uop_valid,
    output logic        uop_ready,
    input  rae_uop_t    uop,
    rae_out_if.source   result
);

    localparam int RW = $clog2(NUM_REGISTERS);
    localparam logic [RAE_DIV_CW-1:0] DIV_LAST = RAE_DIV_CW'(RAE_DIV_STEPS - 1);

    back_state_t state_reg;
    back_state_t state_next;

    logic [31:0]              rf_mem [NUM_REGISTERS];
    logic [NUM_REGISTERS-1:0] rf_vld_reg;

    rae_uop_t    item_reg;
    logic [31:0] a_raw_reg;
    logic [31:0] b_raw_reg;
    logic        a_vld_reg;
    logic        b_vld_reg;
    logic [31:0] a_op;
    logic [31:0] b_op;

    logic [31:0] res_reg;
    logic        wr_reg;
    logic [1:0]  status_reg;

    logic [31:0]           rem_reg;
    logic [31:0]           quo_reg;
    logic [31:0]           dvs_reg;
    logic                  neg_reg;
    logic [RAE_DIV_CW-1:0] div_cnt_reg;
    logic [32:0]           shifted;
    logic [32:0]           diff;
    logic                  ge;

    logic [31:0] cyc_reg;
    logic [31:0] ins_reg;
    logic [32:0] cyc_sum;
    logic [32:0] ins_sum;
    logic [31:0] cyc_next;
    logic [31:0] ins_next;

    logic               out_vld_reg;
    logic [7:0]         out_index_reg;
    logic signed [31:0] out_value_reg;
    logic               out_wr_reg;
    logic [2:0]         out_lat_reg;
    logic [31:0]        out_cyc_reg;
    logic [31:0]        out_ins_reg;
    logic [1:0]         out_status_reg;

    logic out_free;
    logic pop;
    logic div_start;
    logic load_out;

    assign a_op = a_vld_reg ? a_raw_reg : '0;
    assign b_op = item_reg.right_is_reg ? (b_vld_reg ? b_raw_reg : '0)
                                        : {24'd0, item_reg.rb};
    assign out_free = !out_vld_reg || result.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (uop_valid)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                if (!item_reg.idx_err && item_reg.kind == OPK_DIV && b_op != '0)
                begin
                    state_next = BK_DIV;
                end
                else
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DIV:
            begin
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = BK_FIX;
                end
            end
            BK_FIX:
            begin
                state_next = BK_DONE;
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        uop_ready = state_reg == BK_IDLE;
        div_start = (state_reg == BK_EXEC) && !item_reg.idx_err &&
                    (item_reg.kind == OPK_DIV) && (b_op != '0);
        load_out  = (state_reg == BK_DONE) && out_free;
    end

    assign pop = uop_valid && uop_ready;

    // restoring divide step on magnitudes, one quotient bit per cycle
    assign shifted = {rem_reg, quo_reg[31]};
    assign ge      = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    assign cyc_sum  = {1'b0, cyc_reg} + {30'd0, item_reg.latency};
    assign ins_sum  = {1'b0, ins_reg} + 33'd1;
    assign cyc_next = cyc_sum[32] ? '1 : cyc_sum[31:0];
    assign ins_next = ins_sum[32] ? '1 : ins_sum[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            div_cnt_reg <= '0;
            rf_vld_reg  <= '0;
            cyc_reg     <= 32'd2;
            ins_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (div_start)
            begin
                div_cnt_reg <= '0;
            end
            else if (state_reg == BK_DIV)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (load_out)
            begin
                cyc_reg     <= cyc_next;
                ins_reg     <= ins_next;
                out_vld_reg <= 1'b1;
                if (wr_reg)
                begin
                    rf_vld_reg[item_reg.rd[RW-1:0]] <= 1'b1;
                end
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg  <= uop;
            a_raw_reg <= rf_mem[uop.lb[RW-1:0]];
            b_raw_reg <= rf_mem[uop.rb[RW-1:0]];
            a_vld_reg <= rf_vld_reg[uop.lb[RW-1:0]];
            b_vld_reg <= rf_vld_reg[uop.rb[RW-1:0]];
        end
        if (load_out && wr_reg)
        begin
            rf_mem[item_reg.rd[RW-1:0]] <= res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BK_EXEC:
            begin
                status_reg <= ST_OK;
                wr_reg     <= 1'b1;
                unique case (item_reg.kind)
                    OPK_LDI: res_reg <= {24'd0, item_reg.lb};
                    OPK_ADD: res_reg <= a_op + b_op;
                    OPK_SUB: res_reg <= a_op - b_op;
                    OPK_MUL: res_reg <= a_op * b_op;
                    OPK_DIV:
                    begin
                        res_reg <= '0;
                        if (b_op == '0)
                        begin
                            wr_reg     <= 1'b0;
                            status_reg <= ST_DIV0;
                        end
                    end
                    default: res_reg <= '0;
                endcase
                if (item_reg.idx_err)
                begin
                    wr_reg     <= 1'b0;
                    status_reg <= ST_IDX;
                end
                rem_reg <= '0;
                quo_reg <= a_op[31] ? -a_op : a_op;
                dvs_reg <= b_op[31] ? -b_op : b_op;
                neg_reg <= a_op[31] ^ b_op[31];
            end
            BK_DIV:
            begin
                rem_reg <= ge ? diff[31:0] : shifted[31:0];
                quo_reg <= {quo_reg[30:0], ge};
            end
            BK_FIX:
            begin
                res_reg <= neg_reg ? -quo_reg : quo_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_index_reg  <= item_reg.rd;
            out_value_reg  <= wr_reg ? res_reg : '0;
            out_wr_reg     <= wr_reg;
            out_lat_reg    <= item_reg.latency;
            out_cyc_reg    <= cyc_next;
            out_ins_reg    <= ins_next;
            out_status_reg <= status_reg;
        end
    end

    assign result.valid             = out_vld_reg;
    assign result.written_index     = out_index_reg;
    assign result.written_value     = out_value_reg;
    assign result.did_write         = out_wr_reg;
    assign result.latency_cycles    = out_lat_reg;
    assign result.cycle_total       = out_cyc_reg;
    assign result.instruction_total = out_ins_reg;
    assign result.status_code       = out_status_reg;

endmodule

FILE: sv/register_alu_instruction_executor.sv
// Top level of the register ALU instruction executor: front end, queue, back end.
//
//  channel   modport            items
//  instr     rae_in_if.sink     opcode_byte, dest_index, left_byte, right_byte
//  result    rae_out_if.source  index, value, did_write, latency, totals, status
//
// In the back end, load, add, subtract, multiply and faulted items go from EXEC
// to DONE; divide passes the one-bit-per-cycle divider (32 steps) and sign fix.
// The two-entry queue accepts until full while the back end or the result waits.
// Reset clears the register file valid bits, sets the cycle count to 2 and the
// instruction count to 0; the block is ready as soon as reset is released.
module register_alu_instruction_executor
    import rae_pkg::*;
#(
    parameter int NUM_REGISTERS = RAE_NUM_REGISTERS
)
(
    input  logic       clk,
    input  logic       rst_n,
    rae_in_if.sink     instr,
    rae_out_if.source  result
);

    logic     f_valid;
    logic     f_ready;
    rae_uop_t f_uop;
    logic     q_valid;
    logic     q_ready;
    rae_uop_t q_uop;

    rae_front #(
        .NUM_REGISTERS (NUM_REGISTERS)
    ) u_front (
        .instr     (instr),
        .uop_valid (f_valid),
        .uop_ready (f_ready),
        .uop       (f_uop)
    );

    rae_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_uop),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_uop)
    );

    rae_back #(
        .NUM_REGISTERS (NUM_REGISTERS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .uop_valid (q_valid),
        .uop_ready (q_ready),
        .uop       (q_uop),
        .result    (result)
    );

    a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.did_write |-> result.status_code == ST_OK)
        else $error("write reported with fault status");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.did_write |->
            result.written_value == '0 && result.status_code != ST_OK)
        else $error("unwritten item carries a value or ok status");

    a_div0_lat: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status_code == ST_DIV0 |-> result.latency_cycles == LAT_DIV)
        else $error("divide-by-zero on a non-divide latency");

    a_totals_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready) ##1 result.valid |->
            result.instruction_total >= $past(result.instruction_total) &&
            result.cycle_total >= $past(result.cycle_total))
        else $error("running totals went backward");

endmodule
